// ===== sv/vector_rotate_degrees_defines.svh =====
// Assertion macros for the vector rotator.
`ifndef VECTOR_ROTATE_DEGREES_DEFINES_SVH
`define VECTOR_ROTATE_DEGREES_DEFINES_SVH
`ifndef SYNTHESIS
`define VRD_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("vrd assertion failed");
`define VRD_ASSERT_DELAY(lbl, clk, rst_n, ante, n, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> ##n (cons)) \
		else $error("vrd delayed assertion failed");
`else
`define VRD_ASSERT_IMPL(lbl, clk, rst_n, ante, cons)
`define VRD_ASSERT_DELAY(lbl, clk, rst_n, ante, n, cons)
`endif
`endif

// ===== sv/vrd_pkg.sv =====
// Shared types, constants and the arctangent table of the vector rotator.
`timescale 1ns / 1ps
`default_nettype none
package vrd_pkg;

	localparam int GUARD = 8;
	// 32 bit input, guard bits, two bits of CORDIC growth headroom
	localparam int XW = 32 + GUARD + 2;
	localparam int ZW = 32;

	localparam logic [31:0] INV_GAIN_Q32 = 32'd2608131496;
	// round(2^32 * pi / 180)
	localparam logic [26:0] DEG_TO_RAD_Q32 = 27'd74961321;

	typedef struct packed {
		logic                 valid;
		logic signed [XW-1:0] x;
		logic signed [XW-1:0] y;
		logic signed [ZW-1:0] z;
	} cord_t;

	// atan(2^-i) in Q2.30 radians
	function automatic logic signed [ZW-1:0] atan_q30(input int unsigned idx);
		case (idx)
			0: return 32'sd843314857;
			1: return 32'sd497837829;
			2: return 32'sd263043837;
			3: return 32'sd133525159;
			4: return 32'sd67021687;
			5: return 32'sd33543516;
			6: return 32'sd16775851;
			7: return 32'sd8388437;
			8: return 32'sd4194283;
			9: return 32'sd2097149;
			10: return 32'sd1048576;
			11: return 32'sd524288;
			12: return 32'sd262144;
			13: return 32'sd131072;
			14: return 32'sd65536;
			15: return 32'sd32768;
			16: return 32'sd16384;
			17: return 32'sd8192;
			18: return 32'sd4096;
			19: return 32'sd2048;
			20: return 32'sd1024;
			21: return 32'sd512;
			22: return 32'sd256;
			23: return 32'sd128;
			24: return 32'sd64;
			25: return 32'sd32;
			26: return 32'sd16;
			27: return 32'sd8;
			28: return 32'sd4;
			29: return 32'sd2;
			default: return '0;
		endcase
	endfunction

endpackage
`default_nettype wire

// ===== sv/vrd_prep.sv =====
// Front pipeline: angle reduction mod 360, half-turn fold, gain removal, degrees to radians.
`timescale 1ns / 1ps
`default_nettype none
module vrd_prep #(
	parameter int FRACTION_BITS = 16
) (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 start,
	input  wire  signed [31:0]  x_in,
	input  wire  signed [31:0]  y_in,
	input  wire  signed [31:0]  angle_degrees,
	output vrd_pkg::cord_t      head
);

	localparam int FB = FRACTION_BITS;
	localparam int XW = vrd_pkg::XW;
	localparam int ZW = vrd_pkg::ZW;
	// 360 = 45 * 8: the low FB+3 bits pass, the rest is reduced mod 45
	localparam int LOW_W = FB + 3;
	localparam int VW = 32 - LOW_W;
	localparam int UW = VW + 1;
	localparam int K45 = (2 ** (VW - 1) + 44) / 45;
	localparam int SH = UW + 6;
	localparam int MW = SH - 5;
	localparam int QW = UW - 5;
	localparam int DW = (UW + 1 > 7) ? UW + 1 : 7;
	localparam logic [MW-1:0] RECIP = MW'((2 ** SH) / 45);
	localparam int RS = 32 - vrd_pkg::GUARD;
	localparam int TW = FB + 10;
	localparam int FW = FB + 8;
	localparam int PZW = FW + 28;
	localparam logic signed [TW-1:0] FULL = TW'(360) << FB;
	localparam logic signed [TW-1:0] HALF = TW'(180) << FB;
	localparam logic signed [TW-1:0] QUARTER = TW'(90) << FB;

	// stage 1: reciprocal product for mod 45, gain products
	logic [VW-1:0]       v_c;
	logic [UW-1:0]       u_c;
	logic [UW+MW-1:0]    prod_c;
	logic signed [64:0]  px_c, py_c;

	assign v_c = angle_degrees[31:LOW_W];
	assign u_c = UW'({v_c[VW-1], v_c}) + UW'(45 * K45);
	assign prod_c = (UW + MW)'(u_c) * (UW + MW)'(RECIP);
	assign px_c = 65'(x_in) * 65'($signed({1'b0, vrd_pkg::INV_GAIN_Q32}));
	assign py_c = 65'(y_in) * 65'($signed({1'b0, vrd_pkg::INV_GAIN_Q32}));

	logic                vld_s1;
	logic [UW-1:0]       u_s1;
	logic [UW+MW-1:0]    prod_s1;
	logic [LOW_W-1:0]    low_s1;
	logic signed [64:0]  px_s1, py_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= start;
		end
	end

	always_ff @(posedge clk) begin
		u_s1    <= u_c;
		prod_s1 <= prod_c;
		low_s1  <= angle_degrees[LOW_W-1:0];
		px_s1   <= px_c;
		py_s1   <= py_c;
	end

	// stage 2: remainder estimate (below 90), rounded prescaled vector
	logic [QW-1:0]       q_c;
	logic [DW-1:0]       diff_c;
	logic signed [65:0]  sx_c, sy_c;

	assign q_c = prod_s1[UW+MW-1:SH];
	assign diff_c = DW'(u_s1) - DW'(q_c) * DW'(45);
	assign sx_c = {px_s1[64], px_s1} + (66'sd1 <<< (RS - 1));
	assign sy_c = {py_s1[64], py_s1} + (66'sd1 <<< (RS - 1));

	logic                vld_s2;
	logic [6:0]          r0_s2;
	logic [LOW_W-1:0]    low_s2;
	logic signed [XW-1:0] x_s2, y_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else begin
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		r0_s2  <= diff_c[6:0];
		low_s2 <= low_s1;
		x_s2   <= sx_c[RS +: XW];
		y_s2   <= sy_c[RS +: XW];
	end

	// stage 3: final remainder, wrap into (-180, 180], negate to counterclockwise
	logic [6:0]            r45_c;
	logic [FB+8:0]         r_c;
	logic signed [TW-1:0]  rs_c, theta_c;

	assign r45_c = (r0_s2 >= 7'd45) ? r0_s2 - 7'd45 : r0_s2;
	assign r_c = {r45_c[5:0], low_s2};
	assign rs_c = $signed({1'b0, r_c});
	assign theta_c = (rs_c > HALF) ? FULL - rs_c : -rs_c;

	logic                  vld_s3;
	logic signed [TW-1:0]  theta_s3;
	logic signed [XW-1:0]  x_s3, y_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s3 <= 1'b0;
		end else begin
			vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		theta_s3 <= theta_c;
		x_s3     <= x_s2;
		y_s3     <= y_s2;
	end

	// stage 4: half-turn fold into [-90, 90]
	logic                  vld_s4;
	logic signed [FW-1:0]  theta_s4;
	logic signed [XW-1:0]  x_s4, y_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s4 <= 1'b0;
		end else begin
			vld_s4 <= vld_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (theta_s3 > QUARTER) begin
			theta_s4 <= FW'(theta_s3 - HALF);
			x_s4     <= -x_s3;
			y_s4     <= -y_s3;
		end else if (theta_s3 < -QUARTER) begin
			theta_s4 <= FW'(theta_s3 + HALF);
			x_s4     <= -x_s3;
			y_s4     <= -y_s3;
		end else begin
			theta_s4 <= FW'(theta_s3);
			x_s4     <= x_s3;
			y_s4     <= y_s3;
		end
	end

	// stage 5: degrees times pi/180
	logic                   vld_s5;
	logic signed [PZW-1:0]  pz_s5;
	logic signed [XW-1:0]   x_s5, y_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s5 <= 1'b0;
		end else begin
			vld_s5 <= vld_s4;
		end
	end

	always_ff @(posedge clk) begin
		pz_s5 <= PZW'(theta_s4) * PZW'($signed({1'b0, vrd_pkg::DEG_TO_RAD_Q32}));
		x_s5  <= x_s4;
		y_s5  <= y_s4;
	end

	// stage 6: round to Q2.30
	logic signed [PZW:0]   sz_c;

	assign sz_c = {pz_s5[PZW-1], pz_s5} + ((PZW + 1)'(1) << (FB + 1));

	logic                  vld_s6;
	logic signed [ZW-1:0]  z_s6;
	logic signed [XW-1:0]  x_s6, y_s6;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s6 <= 1'b0;
		end else begin
			vld_s6 <= vld_s5;
		end
	end

	always_ff @(posedge clk) begin
		z_s6 <= sz_c[FB+2 +: ZW];
		x_s6 <= x_s5;
		y_s6 <= y_s5;
	end

	assign head = '{valid: vld_s6, x: x_s6, y: y_s6, z: z_s6};

endmodule
`default_nettype wire

// ===== sv/vrd_cell.sv =====
// One CORDIC rotation cell: a shift-add step on x, y and the residual angle.
`timescale 1ns / 1ps
`default_nettype none
module vrd_cell #(
	parameter int STEP = 0
) (
	input  wire             clk,
	input  wire             arst_n,
	input  vrd_pkg::cord_t  din,
	output vrd_pkg::cord_t  dout
);

	localparam int XW = vrd_pkg::XW;
	localparam int ZW = vrd_pkg::ZW;
	localparam logic signed [ZW-1:0] ATAN = vrd_pkg::atan_q30(STEP);

	logic signed [XW-1:0] x_c, y_c, dx_c, dy_c;
	logic signed [ZW-1:0] z_c;

	logic                 valid_q;
	logic signed [XW-1:0] x_q, y_q;
	logic signed [ZW-1:0] z_q;

	assign x_c = din.x;
	assign y_c = din.y;
	assign z_c = din.z;
	assign dx_c = y_c >>> STEP;
	assign dy_c = x_c >>> STEP;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			valid_q <= din.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!z_c[ZW-1]) begin
			x_q <= x_c - dx_c;
			y_q <= y_c + dy_c;
			z_q <= z_c - ATAN;
		end else begin
			x_q <= x_c + dx_c;
			y_q <= y_c - dy_c;
			z_q <= z_c + ATAN;
		end
	end

	assign dout = '{valid: valid_q, x: x_q, y: y_q, z: z_q};

endmodule
`default_nettype wire

// ===== sv/vector_rotate_degrees.sv =====
// Top level: clockwise vector rotation by degrees through a chain of CORDIC cells.
`timescale 1ns / 1ps
`default_nettype none
`include "vector_rotate_degrees_defines.svh"
// Rotates (x_in, y_in) clockwise by angle_degrees (Q16.16 by default, any value,
// wrapped mod 360). A new vector is taken on every clock where start is high;
// busy never rises. Each result appears for one cycle with done high, having
// passed through six front stages (mod-360 reduction, fold, gain and radian
// multipliers), one cell per CORDIC iteration, and one rounding and clipping
// stage. There is no output buffering, so results must be captured in the cycle
// done is high. saturated marks a clipped x_out or y_out.
module vector_rotate_degrees #(
	parameter int CORDIC_STEPS  = 16,
	parameter int FRACTION_BITS = 16
) (
	input  wire                clk,
	input  wire                arst_n,
	input  wire                start,
	output logic               busy,
	input  wire  signed [31:0] x_in,
	input  wire  signed [31:0] y_in,
	input  wire  signed [31:0] angle_degrees,
	output logic               done,
	output logic signed [31:0] x_out,
	output logic signed [31:0] y_out,
	output logic               saturated
);

	localparam int XW = vrd_pkg::XW;
	localparam int GUARD = vrd_pkg::GUARD;
	localparam int OW = XW - GUARD + 1;
	localparam int LAT = CORDIC_STEPS + 7;
	localparam logic signed [OW-1:0] MAXV = OW'(32'h7fffffff);
	localparam logic signed [OW-1:0] MINV = ~MAXV;

	vrd_pkg::cord_t chain [CORDIC_STEPS+1];

	assign busy = 1'b0;

	vrd_prep #(
		.FRACTION_BITS(FRACTION_BITS)
	) u_prep (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.x_in         (x_in),
		.y_in         (y_in),
		.angle_degrees(angle_degrees),
		.head         (chain[0])
	);

	for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_cell
		vrd_cell #(
			.STEP(i)
		) u_cell (
			.clk   (clk),
			.arst_n(arst_n),
			.din   (chain[i]),
			.dout  (chain[i+1])
		);
	end

	// drop guard bits with rounding, then clip to 32 bits
	logic signed [XW:0]   xr_c, yr_c;
	logic signed [OW-1:0] xv_c, yv_c;
	logic signed [31:0]   xc_c, yc_c;
	logic                 xs_c, ys_c;

	assign xr_c = {chain[CORDIC_STEPS].x[XW-1], chain[CORDIC_STEPS].x}
		+ ((XW + 1)'(1) << (GUARD - 1));
	assign yr_c = {chain[CORDIC_STEPS].y[XW-1], chain[CORDIC_STEPS].y}
		+ ((XW + 1)'(1) << (GUARD - 1));
	assign xv_c = xr_c[XW:GUARD];
	assign yv_c = yr_c[XW:GUARD];

	always_comb begin
		xs_c = 1'b1;
		if (xv_c > MAXV) begin
			xc_c = 32'sh7fffffff;
		end else if (xv_c < MINV) begin
			xc_c = 32'sh80000000;
		end else begin
			xc_c = xv_c[31:0];
			xs_c = 1'b0;
		end
	end

	always_comb begin
		ys_c = 1'b1;
		if (yv_c > MAXV) begin
			yc_c = 32'sh7fffffff;
		end else if (yv_c < MINV) begin
			yc_c = 32'sh80000000;
		end else begin
			yc_c = yv_c[31:0];
			ys_c = 1'b0;
		end
	end

	logic               done_q;
	logic signed [31:0] x_q, y_q;
	logic               sat_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= chain[CORDIC_STEPS].valid;
		end
	end

	always_ff @(posedge clk) begin
		x_q   <= xc_c;
		y_q   <= yc_c;
		sat_q <= xs_c | ys_c;
	end

	assign done = done_q;
	assign x_out = x_q;
	assign y_out = y_q;
	assign saturated = sat_q;

	logic at_bound_c, half_scale_c;

	assign at_bound_c = (x_out == 32'sh7fffffff) || (x_out == 32'sh80000000)
		|| (y_out == 32'sh7fffffff) || (y_out == 32'sh80000000);
	assign half_scale_c = (x_in[31] == x_in[30]) && (y_in[31] == y_in[30]);

	// every transfer in comes out with done raised
	`VRD_ASSERT_DELAY(a_latency, clk, arst_n, start && !busy, LAT, done)
	// a flagged result sits on a bound
	`VRD_ASSERT_IMPL(a_sat_bound, clk, arst_n, done && saturated, at_bound_c)
	// vectors within half scale never clip
	`VRD_ASSERT_DELAY(a_no_sat_small, clk, arst_n, start && half_scale_c, LAT, !saturated)

endmodule
`default_nettype wire

// ===== test/vector_rotate_degrees_monitor.sv =====
// Monitor for the vector rotator: predicts each rotation and checks every result.
`timescale 1ns / 1ps
module vector_rotate_degrees_monitor #(
	parameter int CORDIC_STEPS  = 16,
	parameter int FRACTION_BITS = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic               busy,
	input  logic signed [31:0] x_in,
	input  logic signed [31:0] y_in,
	input  logic signed [31:0] angle_degrees,
	input  logic               done,
	input  logic signed [31:0] x_out,
	input  logic signed [31:0] y_out,
	input  logic               saturated,
	output int                 errors,
	output int                 pending
);

	localparam int    GUARD_BITS  = 8;
	localparam int    ATAN_STEPS  = 30;
	localparam longint GAIN_INV   = 64'sd2608131496;
	localparam longint DEG_RAD    = 64'sd74961321;
	localparam longint POS_LIMIT  = 64'sd2147483647;
	localparam longint NEG_LIMIT  = -64'sd2147483648;

	typedef struct packed {
		logic signed [31:0] x;
		logic signed [31:0] y;
		logic               sat;
	} rotation_t;

	rotation_t rotation_q[$];
	longint    arctan_q30[ATAN_STEPS];
	int        result_idx;

	initial begin
		arctan_q30 = '{843314857, 497837829, 263043837, 133525159, 67021687,
			33543516, 16775851, 8388437, 4194283, 2097149,
			1048576, 524288, 262144, 131072, 65536,
			32768, 16384, 8192, 4096, 2048,
			1024, 512, 256, 128, 64,
			32, 16, 8, 4, 2};
		errors     = 0;
		pending    = 0;
		result_idx = 0;
	end

	// shift right with round to nearest, ties upward
	function automatic longint round_shift(input longint v, input int s);
		longint biased;
		biased = v + (longint'(1) << (s - 1));
		return biased >>> s;
	endfunction

	function automatic rotation_t rotate_clockwise(input logic signed [31:0] xv,
			input logic signed [31:0] yv, input logic signed [31:0] ang);
		longint    full_turn, half_turn, quarter_turn;
		longint    r, theta, z, px, py, dx, dy;
		rotation_t res;
		full_turn    = longint'(360) << FRACTION_BITS;
		half_turn    = longint'(180) << FRACTION_BITS;
		quarter_turn = longint'(90) << FRACTION_BITS;
		r = longint'(ang) % full_turn;
		if (r < 0)
			r += full_turn;
		if (r > half_turn)
			r -= full_turn;
		theta = -r;
		px = round_shift(longint'(xv) * GAIN_INV, 32 - GUARD_BITS);
		py = round_shift(longint'(yv) * GAIN_INV, 32 - GUARD_BITS);
		// half-turn fold keeps the residual angle in [-90, 90]
		if (theta > quarter_turn) begin
			px = -px;
			py = -py;
			theta -= half_turn;
		end else if (theta < -quarter_turn) begin
			px = -px;
			py = -py;
			theta += half_turn;
		end
		z = round_shift(theta * DEG_RAD, FRACTION_BITS + 2);
		for (int i = 0; i < CORDIC_STEPS && i < ATAN_STEPS; i++) begin
			dx = py >>> i;
			dy = px >>> i;
			if (z >= 0) begin
				px -= dx;
				py += dy;
				z  -= arctan_q30[i];
			end else begin
				px += dx;
				py -= dy;
				z  += arctan_q30[i];
			end
		end
		px = round_shift(px, GUARD_BITS);
		py = round_shift(py, GUARD_BITS);
		res.sat = 1'b0;
		if (px > POS_LIMIT) begin
			px = POS_LIMIT;
			res.sat = 1'b1;
		end else if (px < NEG_LIMIT) begin
			px = NEG_LIMIT;
			res.sat = 1'b1;
		end
		if (py > POS_LIMIT) begin
			py = POS_LIMIT;
			res.sat = 1'b1;
		end else if (py < NEG_LIMIT) begin
			py = NEG_LIMIT;
			res.sat = 1'b1;
		end
		res.x = px[31:0];
		res.y = py[31:0];
		return res;
	endfunction

	task automatic report(input string msg);
		$display("%0t ns: mismatch on result %0d: %s", $time, result_idx, msg);
		errors++;
	endtask

	always @(posedge clk) begin
		rotation_t want;
		if (arst_n) begin
			if (done) begin
				if (rotation_q.size() == 0) begin
					report("result with no transfer outstanding");
				end else begin
					want = rotation_q.pop_front();
					if (x_out !== want.x)
						report($sformatf("x_out %0d, expected %0d", x_out, want.x));
					if (y_out !== want.y)
						report($sformatf("y_out %0d, expected %0d", y_out, want.y));
					if (saturated !== want.sat)
						report($sformatf("saturated %b, expected %b", saturated, want.sat));
				end
				result_idx++;
			end
			if (start && !busy)
				rotation_q.push_back(rotate_clockwise(x_in, y_in, angle_degrees));
			pending = rotation_q.size();
		end
	end

endmodule

// ===== test/vector_rotate_degrees_tb.sv =====
// Testbench top for the vector rotator: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps
module vector_rotate_degrees_tb;

	localparam int CORDIC_STEPS  = 16;
	localparam int FRACTION_BITS = 16;
	localparam int RANDOM_ITEMS  = 1300;
	localparam int ONE_DEG       = 1 << FRACTION_BITS;

	logic               clk;
	logic               arst_n;
	logic               start;
	logic               busy;
	logic signed [31:0] x_in;
	logic signed [31:0] y_in;
	logic signed [31:0] angle_degrees;
	logic               done;
	logic signed [31:0] x_out;
	logic signed [31:0] y_out;
	logic               saturated;
	int                 errors;
	int                 pending;

	vector_rotate_degrees #(
		.CORDIC_STEPS (CORDIC_STEPS),
		.FRACTION_BITS(FRACTION_BITS)
	) dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.x_in         (x_in),
		.y_in         (y_in),
		.angle_degrees(angle_degrees),
		.done         (done),
		.x_out        (x_out),
		.y_out        (y_out),
		.saturated    (saturated)
	);

	vector_rotate_degrees_monitor #(
		.CORDIC_STEPS (CORDIC_STEPS),
		.FRACTION_BITS(FRACTION_BITS)
	) u_mon (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.x_in         (x_in),
		.y_in         (y_in),
		.angle_degrees(angle_degrees),
		.done         (done),
		.x_out        (x_out),
		.y_out        (y_out),
		.saturated    (saturated),
		.errors       (errors),
		.pending      (pending)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#2_000_000;
		$display("Regression FAIL");
		$finish;
	end

	// called at a falling edge; returns at the falling edge after the transfer
	task automatic rotate_vector(input logic signed [31:0] xv, input logic signed [31:0] yv,
			input logic signed [31:0] ang);
		start         = 1'b1;
		x_in          = xv;
		y_in          = yv;
		angle_degrees = ang;
		while (busy)
			@(negedge clk);
		@(negedge clk);
	endtask

	task automatic hold_off(input int cycles);
		if (cycles > 0) begin
			start = 1'b0;
			repeat (cycles) @(negedge clk);
		end
	endtask

	// vector component: full range, small, or near full scale
	function automatic logic signed [31:0] pick_component();
		case ($urandom_range(0, 3))
			0: return $urandom_range(0, 1 << 21) - (1 << 20);
			1: return $urandom_range(0, 1 << 24) + 32'sh7F00_0000;
			2: return 32'sh8000_0000 + $urandom_range(0, 1 << 24);
			default: return $urandom;
		endcase
	endfunction

	function automatic logic signed [31:0] pick_angle();
		case ($urandom_range(0, 3))
			0: return $urandom;
			// multiples of 45 degrees, nudged by up to one lsb
			1: return (int'($urandom_range(0, 32)) - 16) * 45 * ONE_DEG
				+ int'($urandom_range(0, 2)) - 1;
			default: return int'($urandom_range(0, 1440 * ONE_DEG)) - 720 * ONE_DEG;
		endcase
	endfunction

	initial begin
		bit burst;
		arst_n        = 1'b0;
		start         = 1'b0;
		x_in          = '0;
		y_in          = '0;
		angle_degrees = '0;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		rotate_vector(0, 0, 0);
		rotate_vector(ONE_DEG, 0, 90 * ONE_DEG);
		rotate_vector(ONE_DEG, 0, -90 * ONE_DEG);
		rotate_vector(ONE_DEG, ONE_DEG, 180 * ONE_DEG);
		rotate_vector(ONE_DEG, -ONE_DEG, -180 * ONE_DEG);
		rotate_vector(3 * ONE_DEG, 4 * ONE_DEG, 360 * ONE_DEG);
		rotate_vector(3 * ONE_DEG, 4 * ONE_DEG, 270 * ONE_DEG);
		rotate_vector(-5 * ONE_DEG, 7 * ONE_DEG, 30 * ONE_DEG + ONE_DEG / 2);
		rotate_vector(32'sh7FFF_FFFF, 0, 0);
		rotate_vector(32'sh8000_0000, 0, 0);
		rotate_vector(0, 32'sh7FFF_FFFF, 180 * ONE_DEG);
		rotate_vector(0, 32'sh8000_0000, 180 * ONE_DEG);
		// diagonal full-scale vectors clip when turned onto an axis
		rotate_vector(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 45 * ONE_DEG);
		rotate_vector(32'sh8000_0000, 32'sh8000_0000, -45 * ONE_DEG);
		rotate_vector(32'sh7FFF_FFFF, 32'sh8000_0000, -45 * ONE_DEG);
		rotate_vector(32'sh8000_0000, 32'sh7FFF_FFFF, 135 * ONE_DEG);
		rotate_vector(ONE_DEG, 2 * ONE_DEG, 32'sh7FFF_FFFF);
		rotate_vector(ONE_DEG, 2 * ONE_DEG, 32'sh8000_0000);
		rotate_vector(-ONE_DEG, ONE_DEG, -1);
		rotate_vector(-ONE_DEG, ONE_DEG, 1);
		rotate_vector(32'sh7FFF_FFFF, 32'sh8000_0000, 90 * ONE_DEG + 1);
		rotate_vector(32'shFFFF_FFFF, 32'shFFFF_FFFF, 180 * ONE_DEG - 1);
		hold_off(3);

		burst = 1'b0;
		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			if (n % 64 == 0)
				burst = ($urandom_range(0, 3) == 0);
			rotate_vector(pick_component(), pick_component(), pick_angle());
			if (!burst)
				hold_off($urandom_range(0, 7));
		end
		start = 1'b0;

		wait (pending == 0);
		repeat (CORDIC_STEPS + 12) @(negedge clk);
		if (errors == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
